FILE: sv/rad_pkg.sv
// Shared types and constants of the row area downscaler.
`default_nettype none
package rad_pkg;

	localparam int MAX_ROW_PIXELS = 4096;
	localparam int PIX_W = 32;
	localparam int POS_W = 13;
	localparam int IDX_W = 12;
	localparam int WS_W = 44;
	localparam int FP_BITS = 30;
	localparam int SCALE_W = 16;
	localparam int INV_W = 32;
	localparam int PROD_W = 24;
	localparam int TERM_W = 54;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_FRAC = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_STEP = 2'd3;

	localparam logic [POS_W-1:0] WIDTH_RESET = 13'd1;
	localparam logic [POS_W-1:0] WIDTH_MAX = 13'(MAX_ROW_PIXELS);
	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'hffff;
	localparam logic [INV_W-1:0] INV_RESET = 32'h4000_4000;
	localparam logic [INV_W-1:0] INV_MIN = 32'h4000_0000;
	localparam logic [INV_W-1:0] INV_MAX = 32'h8000_0000;

	localparam logic [FP_BITS:0] FP_ONE = 31'h4000_0000;
	localparam logic [TERM_W-1:0] ROUND_HALF = 54'h0000_2000_0000_0000;
	localparam logic [7:0] ALPHA_FULL = 8'hff;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);

	localparam logic [1:0] JOB_COPY = 2'd0;
	localparam logic [1:0] JOB_PAIR = 2'd1;
	localparam logic [1:0] JOB_AREA = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [PIX_W-1:0] pix_a;
		logic [PIX_W-1:0] pix_m;
		logic [PIX_W-1:0] pix_b;
		logic [FP_BITS:0] w1;
		logic [FP_BITS-1:0] w2;
		logic [IDX_W-1:0] index;
		logic last;
	} rad_job_t;

endpackage
`default_nettype wire

FILE: sv/rad_front.sv
// Front end: takes source pixels, tracks row and window position, issues output jobs.
`default_nettype none
module rad_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [rad_pkg::PIX_W-1:0]     pixel_in,
	input  wire logic [rad_pkg::POS_W-1:0]     src_width,
	input  wire logic [rad_pkg::POS_W-1:0]     dst_width,
	input  wire logic [rad_pkg::INV_W-1:0]     inv_step,
	input  wire logic                          q_full,
	output logic                               job_push,
	output rad_pkg::rad_job_t                  job,
	output logic                               busy
);
	import rad_pkg::*;

	logic [POS_W-1:0] sp_q;
	logic [POS_W-1:0] op_q;
	logic [WS_W-1:0] ws_q;
	logic [PIX_W-1:0] hf_q;
	logic [PIX_W-1:0] hm_q;
	logic mv_q;
	logic busy_q;
	logic [PIX_W-1:0] p_q;
	logic [POS_W-1:0] s_q;
	logic rend_q;

	logic acc;
	logic step;
	logic area_go;
	logic mode_copy;
	logic mode_pair;
	logic mode_area;
	logic row_end_a;
	logic hit_first;
	logic hit_mid;

	logic [PIX_W-1:0] it_p;
	logic [POS_W-1:0] it_s;
	logic it_rend;
	logic [PIX_W-1:0] it_hf;
	logic [PIX_W-1:0] it_hm;
	logic it_mv;

	logic [WS_W:0] x2_raw;
	logic [42:0] max_x;
	logic [42:0] x2;
	logic [POS_W-1:0] a2;
	logic [POS_W:0] a1;
	logic [FP_BITS:0] w1;
	logic [FP_BITS-1:0] w2;
	logic span2;
	logic need_ok;
	logic emit;
	logic [POS_W-1:0] op_inc;
	logic op_wrap;
	logic [POS_W-1:0] op_nx;
	logic [WS_W-1:0] ws_nx;
	logic [PIX_W-1:0] hf_nx;
	logic cont;

	assign full = busy_q || q_full;
	assign busy = busy_q;
	assign acc = push && !full;
	assign step = busy_q && !q_full;

	assign mode_copy = (dst_width == src_width);
	assign mode_pair = ({dst_width, 1'b0} == {1'b0, src_width});
	assign mode_area = !mode_copy && !mode_pair;
	assign area_go = (acc && mode_area) || step;

	assign row_end_a = ({1'b0, sp_q} + 14'd1) >= {1'b0, src_width};
	assign hit_first = ({1'b0, sp_q} == ws_q[WS_W-1:FP_BITS]);
	assign hit_mid = ({1'b0, sp_q} == (ws_q[WS_W-1:FP_BITS] + 14'd1));

	assign it_p = busy_q ? p_q : pixel_in;
	assign it_s = busy_q ? s_q : sp_q;
	assign it_rend = busy_q ? rend_q : row_end_a;
	assign it_hf = (!busy_q && hit_first) ? pixel_in : hf_q;
	assign it_hm = (!busy_q && hit_mid) ? pixel_in : hm_q;
	assign it_mv = (!busy_q && hit_mid) || mv_q;

	// window end, clamped to the row end
	assign x2_raw = {1'b0, ws_q} + {13'd0, inv_step};
	assign max_x = {src_width, 30'd0};
	assign x2 = (x2_raw > {2'b00, max_x}) ? max_x : x2_raw[42:0];
	assign a2 = x2[42:FP_BITS];
	assign a1 = ws_q[WS_W-1:FP_BITS];
	assign w1 = FP_ONE - {1'b0, ws_q[FP_BITS-1:0]};
	assign w2 = x2[FP_BITS-1:0];
	assign span2 = {2'b00, a2} >= ({1'b0, a1} + 15'd2);
	assign need_ok = (w2 != '0) ? ({1'b0, a2} <= {1'b0, it_s})
		: ({1'b0, a2} <= ({1'b0, it_s} + 14'd1));
	assign emit = (op_q < dst_width) && (need_ok || it_rend);

	assign op_inc = op_q + 13'd1;
	assign op_wrap = (op_inc[IDX_W-1:0] == '0);
	assign op_nx = op_wrap ? dst_width : {1'b0, op_inc[IDX_W-1:0]};
	assign ws_nx = x2_raw[WS_W-1:0];
	assign hf_nx = (ws_nx[WS_W-1:FP_BITS] == {1'b0, it_s}) ? it_p : it_hf;
	assign cont = !busy_q && !op_wrap;

	always_comb begin
		job = '0;
		job_push = 1'b0;
		if (area_go) begin
			job_push = emit;
			job.kind = JOB_AREA;
			job.pix_a = it_hf;
			job.pix_m = (span2 && it_mv) ? it_hm : '0;
			job.pix_b = it_p;
			job.w1 = w1;
			job.w2 = w2;
			job.index = op_q[IDX_W-1:0];
			job.last = (op_inc == dst_width);
		end else if (mode_copy) begin
			job_push = acc;
			job.kind = JOB_COPY;
			job.pix_a = pixel_in;
			job.index = sp_q[IDX_W-1:0];
			job.last = ({1'b0, sp_q} + 14'd1) >= {1'b0, dst_width};
		end else begin
			job_push = acc && sp_q[0];
			job.kind = JOB_PAIR;
			job.pix_a = hf_q;
			job.pix_b = pixel_in;
			job.index = sp_q[POS_W-1:1];
			job.last = ({1'b0, sp_q[POS_W-1:1]} + 13'd1) >= dst_width;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
			op_q <= '0;
			ws_q <= '0;
			hf_q <= '0;
			hm_q <= '0;
			mv_q <= 1'b0;
			busy_q <= 1'b0;
		end else begin
			if (acc) begin
				sp_q <= row_end_a ? '0 : sp_q + 13'd1;
			end
			if (acc && mode_pair && !sp_q[0]) begin
				hf_q <= pixel_in;
			end
			if (area_go) begin
				busy_q <= 1'b0;
				hm_q <= it_hm;
				if (emit) begin
					hf_q <= hf_nx;
					mv_q <= 1'b0;
					if (cont || !it_rend) begin
						op_q <= op_nx;
						ws_q <= ws_nx;
					end else begin
						op_q <= '0;
						ws_q <= '0;
					end
					if (cont) begin
						busy_q <= 1'b1;
					end
				end else begin
					hf_q <= it_hf;
					if (it_rend) begin
						op_q <= '0;
						ws_q <= '0;
						mv_q <= 1'b0;
					end else begin
						mv_q <= it_mv;
					end
				end
			end else if (acc && row_end_a) begin
				op_q <= '0;
				ws_q <= '0;
				mv_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			p_q <= pixel_in;
			s_q <= sp_q;
			rend_q <= row_end_a;
		end
	end

endmodule
`default_nettype wire

FILE: sv/rad_fifo.sv
// Small job queue between front end and arithmetic back end.
`default_nettype none
module rad_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire rad_pkg::rad_job_t wdata,
	output logic                   full,
	input  wire logic              pop,
	output rad_pkg::rad_job_t      rdata,
	output logic                   empty
);
	import rad_pkg::*;

	rad_job_t mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q;
	logic [FIFO_AW-1:0] rp_q;
	logic [FIFO_AW:0] cnt_q;
	logic wr;
	logic rd;

	assign full = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign wr = push && !full;
	assign rd = pop && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

FILE: sv/rad_back.sv
// Back end: three-stage weighted-sum pipeline whose last stage is the result register.
`default_nettype none
module rad_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [rad_pkg::SCALE_W-1:0]   scale_frac,
	input  wire logic                          q_empty,
	input  wire rad_pkg::rad_job_t             q_job,
	output logic                               q_pop,
	output logic                               empty,
	input  wire logic                          pop,
	output logic [rad_pkg::PIX_W-1:0]          pixel_out,
	output logic [rad_pkg::IDX_W-1:0]          out_index,
	output logic                               row_last
);
	import rad_pkg::*;

	logic en;

	logic v_s1;
	logic area_s1;
	logic [IDX_W-1:0] idx_s1;
	logic last_s1;
	logic [PIX_W-1:0] dir_s1;
	logic [PROD_W-1:0] pa_s1 [3];
	logic [PROD_W-1:0] pm_s1 [3];
	logic [PROD_W-1:0] pb_s1 [3];
	logic [FP_BITS:0] w1_s1;
	logic [FP_BITS-1:0] w2_s1;

	logic v_s2;
	logic area_s2;
	logic [IDX_W-1:0] idx_s2;
	logic last_s2;
	logic [PIX_W-1:0] dir_s2;
	logic [TERM_W-1:0] ta_s2 [3];
	logic [TERM_W-1:0] tb_s2 [3];
	logic [PROD_W-1:0] tm_s2 [3];

	logic v_s3;
	logic [PIX_W-1:0] pix_s3;
	logic [IDX_W-1:0] idx_s3;
	logic last_s3;

	logic [PIX_W-1:0] dir_c;
	logic [PROD_W-1:0] pa_c [3];
	logic [PROD_W-1:0] pm_c [3];
	logic [PROD_W-1:0] pb_c [3];
	logic [TERM_W:0] ta_c [3];
	logic [TERM_W-1:0] tb_c [3];
	logic [TERM_W-1:0] acc_c [3];
	logic [PIX_W-1:0] area_pix;
	logic [8:0] avg_c [3];

	assign en = !v_s3 || pop;
	assign q_pop = en && !q_empty;
	assign empty = !v_s3;
	assign pixel_out = pix_s3;
	assign out_index = idx_s3;
	assign row_last = last_s3;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			avg_c[c] = {1'b0, q_job.pix_a[8*c +: 8]} + {1'b0, q_job.pix_b[8*c +: 8]} + 9'd1;
			pa_c[c] = q_job.pix_a[8*c +: 8] * scale_frac;
			pm_c[c] = q_job.pix_m[8*c +: 8] * scale_frac;
			pb_c[c] = q_job.pix_b[8*c +: 8] * scale_frac;
		end
		if (q_job.kind == JOB_COPY) begin
			dir_c = q_job.pix_a;
		end else begin
			dir_c = {ALPHA_FULL, avg_c[2][8:1], avg_c[1][8:1], avg_c[0][8:1]};
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			ta_c[c] = pa_s1[c] * w1_s1;
			tb_c[c] = pb_s1[c] * w2_s1;
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			acc_c[c] = ta_s2[c] + tb_s2[c] + {tm_s2[c], 30'd0} + ROUND_HALF;
		end
		area_pix = {ALPHA_FULL, acc_c[2][53:46], acc_c[1][53:46], acc_c[0][53:46]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= !q_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			area_s1 <= (q_job.kind == JOB_AREA);
			idx_s1 <= q_job.index;
			last_s1 <= q_job.last;
			dir_s1 <= dir_c;
			w1_s1 <= q_job.w1;
			w2_s1 <= q_job.w2;
			for (int c = 0; c < 3; c++) begin
				pa_s1[c] <= pa_c[c];
				pm_s1[c] <= pm_c[c];
				pb_s1[c] <= pb_c[c];
			end

			area_s2 <= area_s1;
			idx_s2 <= idx_s1;
			last_s2 <= last_s1;
			dir_s2 <= dir_s1;
			for (int c = 0; c < 3; c++) begin
				ta_s2[c] <= ta_c[c][TERM_W-1:0];
				tb_s2[c] <= tb_c[c];
				tm_s2[c] <= pm_s1[c];
			end

			pix_s3 <= area_s2 ? area_pix : dir_s2;
			idx_s3 <= idx_s2;
			last_s3 <= last_s2;
		end
	end

endmodule
`default_nettype wire

FILE: sv/row_area_downscaler_unit.sv
// Top level: row area downscaler with configuration registers.
// Throughput: one pixel per clock in copy and pair rows while the job queue has room;
// in area rows a beat that emits an output closes the input while the front end tries
// a second window. A result passes the queue write, then the three-stage multiply pipe.
// Reset (arst_n low): row position, window and queues clear; registers take defaults.
`default_nettype none
module row_area_downscaler_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             push,
	output logic                                  full,
	input  wire logic [rad_pkg::PIX_W-1:0]        pixel_in,
	output logic                                  empty,
	input  wire logic                             pop,
	output logic [rad_pkg::PIX_W-1:0]             pixel_out,
	output logic [rad_pkg::IDX_W-1:0]             out_index,
	output logic                                  row_last,
	input  wire logic                             cfg_we,
	input  wire logic [rad_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [rad_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import rad_pkg::*;

	logic [POS_W-1:0] src_width_q;
	logic [POS_W-1:0] dst_width_q;
	logic [SCALE_W-1:0] scale_q;
	logic [INV_W-1:0] inv_q;
	logic [POS_W-1:0] wr_width;
	logic [POS_W-1:0] sat_width;
	logic [INV_W-1:0] sat_inv;

	logic job_push;
	rad_job_t job_w;
	rad_job_t job_r;
	logic q_full;
	logic q_empty;
	logic q_pop;
	logic fr_busy;

	assign wr_width = cfg_wdata[POS_W-1:0];
	assign sat_width = (wr_width == '0) ? WIDTH_RESET
		: ((wr_width > WIDTH_MAX) ? WIDTH_MAX : wr_width);
	assign sat_inv = (cfg_wdata < INV_MIN) ? INV_MIN
		: ((cfg_wdata > INV_MAX) ? INV_MAX : cfg_wdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q <= WIDTH_RESET;
			dst_width_q <= WIDTH_RESET;
			scale_q <= SCALE_RESET;
			inv_q <= INV_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SRC_WIDTH: src_width_q <= sat_width;
				REG_DST_WIDTH: dst_width_q <= sat_width;
				REG_SCALE_FRAC: scale_q <= cfg_wdata[SCALE_W-1:0];
				REG_INV_STEP: inv_q <= sat_inv;
				default: ;
			endcase
		end
	end

	rad_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.pixel_in  (pixel_in),
		.src_width (src_width_q),
		.dst_width (dst_width_q),
		.inv_step  (inv_q),
		.q_full    (q_full),
		.job_push  (job_push),
		.job       (job_w),
		.busy      (fr_busy)
	);

	rad_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job_w),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (job_r),
		.empty  (q_empty)
	);

	rad_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.scale_frac (scale_q),
		.q_empty    (q_empty),
		.q_job      (job_r),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.pixel_out  (pixel_out),
		.out_index  (out_index),
		.row_last   (row_last)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !q_full)
		else $error("job issued into a full queue");

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		fr_busy |-> full)
		else $error("input open while second window pending");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fr_busy) |-> $past(push && !full && job_push))
		else $error("second window pending without an issuing beat");

endmodule
`default_nettype wire

FILE: tb/row_area_downscaler_unit_tb.sv
// Self-checking testbench for the row area downscaler: copy, pair and area rows.
`timescale 1ns / 1ps
module row_area_downscaler_unit_tb;
	import rad_pkg::*;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic [IDX_W-1:0] idx;
		logic last;
	} out_pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic [PIX_W-1:0] pixel_in = '0;
	logic pop = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	wire full, empty, row_last;
	wire [PIX_W-1:0] pixel_out;
	wire [IDX_W-1:0] out_index;

	row_area_downscaler_unit dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .pixel_in(pixel_in),
		.empty(empty), .pop(pop), .pixel_out(pixel_out), .out_index(out_index),
		.row_last(row_last),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// shadow registers and row state
	int unsigned src_w = 1, dst_w = 1;
	logic [SCALE_W-1:0] scale = SCALE_RESET;
	logic [63:0] inv = 64'(INV_RESET);
	int unsigned src_pos = 0, out_pos = 0;
	logic [63:0] win = '0;
	logic [PIX_W-1:0] first_px = '0, mid_px = '0;
	bit mid_ok = 0;

	logic [PIX_W-1:0] pix_q[$];
	out_pixel_t due_pixels[$];
	int errors = 0, pix_in_cnt = 0, pix_out_cnt = 0, reg_writes = 0;
	int hold_req = 0, hold_ack = 0, hold_left = 0;
	bit calm = 0;

	function automatic void flag_error(input string msg);
		if (errors < 10)
			$display("ERROR @%0t: %s", $time, msg);
		errors++;
	endfunction

	function automatic void add_pixel(input logic [PIX_W-1:0] px);
		pix_q = {pix_q, px};
	endfunction

	function automatic void queue_result(input logic [PIX_W-1:0] px, input int unsigned idx,
			input bit last);
		out_pixel_t o;
		o.pix = px;
		o.idx = idx[IDX_W-1:0];
		o.last = last;
		due_pixels = {due_pixels, o};
	endfunction

	function automatic logic [PIX_W-1:0] area_mix(input logic [PIX_W-1:0] a, input logic [63:0] wa,
			input logic [PIX_W-1:0] m, input logic [PIX_W-1:0] b, input logic [63:0] wb);
		logic [63:0] acc;
		logic [PIX_W-1:0] r;
		int c;
		r = {ALPHA_FULL, 24'h0};
		for (c = 0; c < 3; c++) begin
			acc = 64'(a[8*c+:8]) * wa + (64'(m[8*c+:8]) << FP_BITS) + 64'(b[8*c+:8]) * wb;
			acc = (acc * 64'(scale) + 64'(ROUND_HALF)) >> (FP_BITS + SCALE_W);
			r[8*c+:8] = acc[7:0];
		end
		return r;
	endfunction

	function automatic void area_step(input logic [PIX_W-1:0] p, input int unsigned s,
			input bit row_end);
		logic [63:0] max_x, x1, x2, a1, a2, w1, w2;
		longint need;
		logic [PIX_W-1:0] mid;
		int n;
		max_x = 64'(src_w) << FP_BITS;
		n = 0;
		if ((win >> FP_BITS) == 64'(s))
			first_px = p;
		if ((win >> FP_BITS) + 1 == 64'(s)) begin
			mid_px = p;
			mid_ok = 1;
		end
		while (n < 2 && out_pos < dst_w) begin
			x1 = win;
			x2 = x1 + inv;
			if (x2 > max_x)
				x2 = max_x;
			a1 = x1 >> FP_BITS;
			a2 = x2 >> FP_BITS;
			w1 = (64'd1 << FP_BITS) - (x1 - (a1 << FP_BITS));
			w2 = x2 - (a2 << FP_BITS);
			need = (w2 != 0) ? longint'(a2) : longint'(a2) - 1;
			if (!(need <= longint'(s) || row_end))
				break;
			mid = (longint'(a2) - longint'(a1) >= 2 && mid_ok) ? mid_px : '0;
			queue_result(area_mix(first_px, w1, mid, (w2 != 0) ? p : '0, w2), out_pos,
				out_pos + 1 == dst_w);
			n++;
			out_pos = (out_pos + 1) & 32'hfff;
			win = x1 + inv;
			mid_ok = 0;
			if ((win >> FP_BITS) == 64'(s))
				first_px = p;
			if (out_pos == 0) begin
				out_pos = dst_w;
				break;
			end
		end
	endfunction

	function automatic void scale_pixel(input logic [PIX_W-1:0] p);
		int unsigned s;
		bit row_end;
		logic [PIX_W-1:0] r;
		logic [8:0] t;
		int c;
		s = src_pos;
		row_end = s + 1 >= src_w;
		if (dst_w == src_w)
			queue_result(p, s, s + 1 >= dst_w);
		else if (dst_w * 2 == src_w) begin
			if (!s[0])
				first_px = p;
			else begin
				r = {ALPHA_FULL, 24'h0};
				for (c = 0; c < 3; c++) begin
					t = first_px[8*c+:8] + p[8*c+:8] + 9'd1;
					r[8*c+:8] = t[8:1];
				end
				queue_result(r, s >> 1, (s >> 1) + 1 >= dst_w);
			end
		end else
			area_step(p, s, row_end);
		if (row_end) begin
			src_pos = 0;
			out_pos = 0;
			win = '0;
			mid_ok = 0;
		end else
			src_pos = (s + 1) & 32'h1fff;
	endfunction

	// input side: beats come from pix_q, front item is the one on the port
	always @(posedge clk) begin
		bit took, offer;
		took = arst_n && push && !full;
		if (took) begin
			scale_pixel(pix_q.pop_front());
			pix_in_cnt++;
		end
		if (!arst_n)
			offer = 0;
		else if (push && !took)
			offer = 1;
		else
			offer = pix_q.size() != 0 && (calm || $urandom_range(99) >= 23);
		push <= offer;
		if (offer)
			pixel_in <= pix_q[0];
	end

	// output side
	always @(posedge clk) begin
		out_pixel_t want;
		bit take;
		if (arst_n && pop && !empty) begin
			pix_out_cnt++;
			if (due_pixels.size() == 0)
				flag_error($sformatf("unexpected beat: pixel %h index %0d last %b",
					pixel_out, out_index, row_last));
			else begin
				want = due_pixels.pop_front();
				if (want.pix !== pixel_out || want.idx !== out_index || want.last !== row_last)
					flag_error($sformatf({"mismatch: exp pixel %h index %0d last %b, ",
						"got pixel %h index %0d last %b"}, want.pix, want.idx, want.last,
						pixel_out, out_index, row_last));
			end
		end
		if (hold_ack != hold_req) begin
			hold_ack = hold_req;
			hold_left = 150;
		end
		if (hold_left != 0) begin
			hold_left--;
			take = 0;
		end else
			take = calm || $urandom_range(99) >= 23;
		pop <= take;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		logic [31:0] w;
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
		case (idx)
		REG_SRC_WIDTH, REG_DST_WIDTH: begin
			w = data & 32'h1fff;
			if (w < 1)
				w = 1;
			if (w > MAX_ROW_PIXELS)
				w = MAX_ROW_PIXELS;
			if (idx == REG_SRC_WIDTH)
				src_w = w;
			else
				dst_w = w;
		end
		REG_SCALE_FRAC: scale = data[SCALE_W-1:0];
		REG_INV_STEP: begin
			w = data;
			if (w < INV_MIN)
				w = INV_MIN;
			if (w > INV_MAX)
				w = INV_MAX;
			inv = 64'(w);
		end
		default: ;
		endcase
	endtask

	// consistent geometry: scale = (dst<<16)/src, inv = 2^46/scale
	task automatic set_row_shape(input int unsigned s, input int unsigned d);
		logic [31:0] sc;
		sc = (d << 16) / s;
		if (sc > 32'hffff)
			sc = 32'hffff;
		write_reg(REG_SRC_WIDTH, s);
		write_reg(REG_DST_WIDTH, d);
		write_reg(REG_SCALE_FRAC, sc);
		write_reg(REG_INV_STEP, 32'((64'd1 << 46) / sc));
	endtask

	task automatic settle();
		do @(posedge clk);
		while (pix_q.size() != 0 || push || due_pixels.size() != 0);
		repeat (12) @(posedge clk);
	endtask

	function automatic logic [PIX_W-1:0] pick_pixel();
		case ($urandom_range(7))
		0: return '0;
		1: return '1;
		default: return $urandom;
		endcase
	endfunction

	task automatic run_rows(input int unsigned rows);
		repeat (rows * src_w)
			add_pixel(pick_pixel());
		settle();
	endtask

	initial begin
		int unsigned s, d, rows, rand_fed, phase_no;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry is a one-pixel copy row
		add_pixel(32'h0000_0000);
		add_pixel(32'hffff_ffff);
		add_pixel(32'h0123_4567);
		settle();
		// zero widths saturate to one; scale 0x8000 and step at its floor
		write_reg(REG_SRC_WIDTH, 32'h0);
		write_reg(REG_DST_WIDTH, 32'h0);
		write_reg(REG_SCALE_FRAC, 32'h8000);
		write_reg(REG_INV_STEP, 32'h0);
		add_pixel(32'ha5a5_a5a5);
		settle();
		// pair averaging, rounding up on odd sums
		set_row_shape(2, 1);
		add_pixel(32'h0000_0000);
		add_pixel(32'hffff_ffff);
		add_pixel(32'hffff_ffff);
		add_pixel(32'hffff_ffff);
		add_pixel(32'h0101_0101);
		add_pixel(32'h0000_0000);
		settle();
		set_row_shape(3, 2);
		add_pixel(32'hffff_ffff);
		add_pixel(32'h0000_0000);
		add_pixel(32'hffff_ffff);
		settle();
		// oversized step saturates to the maximum: channel sums wrap past 8 bits
		write_reg(REG_SCALE_FRAC, 32'hffff);
		write_reg(REG_INV_STEP, 32'hffff_ffff);
		repeat (3) add_pixel(32'hffff_ffff);
		settle();
		// step below the floor saturates to one source pixel
		write_reg(REG_INV_STEP, 32'h0);
		repeat (3) add_pixel(32'hffff_ffff);
		settle();
		set_row_shape(5, 4);
		run_rows(1);

		// output side holds off while the input keeps offering beats
		set_row_shape(30, 30);
		hold_req++;
		run_rows(2);
		// input pauses mid-phase until everything has drained
		set_row_shape(24, 17);
		run_rows(2);
		run_rows(2);

		rand_fed = 0;
		phase_no = 0;
		while (rand_fed < 800) begin
			calm = phase_no >= 4 && phase_no < 8;
			case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: begin
				s = ($urandom_range(7) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
				set_row_shape(s, $urandom_range((s + 1) / 2, s));
			end
			6: begin
				s = $urandom_range(1, 40);
				set_row_shape(s, s);
			end
			7: begin
				d = $urandom_range(1, 20);
				set_row_shape(2 * d, d);
			end
			default: begin
				// unrelated widths, scale and step; upper data bits are don't-care
				write_reg(REG_SRC_WIDTH, ($urandom & 32'hffff_e000) | $urandom_range(0, 40));
				write_reg(REG_DST_WIDTH, ($urandom & 32'hffff_e000) | $urandom_range(0, 48));
				write_reg(REG_SCALE_FRAC, $urandom);
				case ($urandom_range(2))
				0: write_reg(REG_INV_STEP, $urandom);
				1: write_reg(REG_INV_STEP, $urandom_range(INV_MIN, INV_MAX));
				default: write_reg(REG_INV_STEP, $urandom_range(0, INV_MIN));
				endcase
			end
			endcase
			rows = (src_w > 40) ? 1 : $urandom_range(1, 3);
			rand_fed += rows * src_w;
			run_rows(rows);
			phase_no++;
		end
		calm = 0;

		// oversized width saturates to the maximum; start of a full-width copy row
		write_reg(REG_SRC_WIDTH, 32'h1fff);
		write_reg(REG_DST_WIDTH, MAX_ROW_PIXELS);
		repeat (40) add_pixel(pick_pixel());
		settle();

		if (due_pixels.size() != 0)
			flag_error($sformatf("%0d expected beats never arrived", due_pixels.size()));
		$display("Sent %0d source pixels and checked %0d output pixels over %0d register writes,",
			pix_in_cnt, pix_out_cnt, reg_writes);
		$display("covering copy, pair and area rows, odd settings and a saturated row width.");
		if (errors == 0)
			$display("PASS row_area_downscaler_unit");
		else
			$display("FAIL row_area_downscaler_unit");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL row_area_downscaler_unit");
		$finish;
	end

endmodule

FILE: row_area_downscaler_unit.f
sv/rad_pkg.sv
sv/rad_front.sv
sv/rad_fifo.sv
sv/rad_back.sv
sv/row_area_downscaler_unit.sv
tb/row_area_downscaler_unit_tb.sv
